>>> hw/rtl/aafc_pkg.sv
// aafc_pkg: shared types, constants and the plane coefficient function for
// the box frustum cull block. No dependencies.
`timescale 1ns / 1ps

package aafc_pkg;

    localparam int ENTRY_W = 16;            // one Q4.12 matrix entry
    localparam int ROW_W   = 4 * ENTRY_W;   // one configuration register
    localparam int COEF_W  = ENTRY_W + 1;   // sum or difference of two entries
    localparam int PLANE_N = 6;
    localparam int AXIS_N  = 3;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_W = 2'd3;

    localparam int VIS_W = 2;
    localparam logic [VIS_W-1:0] VIS_OUTSIDE = 2'd0;
    localparam logic [VIS_W-1:0] VIS_PARTIAL = 2'd1;
    localparam logic [VIS_W-1:0] VIS_INSIDE  = 2'd2;

    // plane order: left, right, bottom, top, near, far
    localparam logic [1:0] PLANE_COL [PLANE_N] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic [PLANE_N-1:0] PLANE_USES_COL3 = 6'b101111;
    localparam logic [PLANE_N-1:0] PLANE_NEG       = 6'b101010;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        t_coef nx;
        t_coef ny;
        t_coef nz;
        t_coef d;
    } t_plane;

    typedef struct packed {
        logic far_neg;    // p-corner behind the plane
        logic near_neg;   // n-corner behind the plane
    } t_plane_flags;

    function automatic t_coef plane_coef(input logic [ROW_W-1:0] row, input int unsigned p);
        logic [ENTRY_W-1:0] e_col;
        logic [ENTRY_W-1:0] e_c3;
        t_coef c;
        t_coef c3;
        e_col = row[ENTRY_W*PLANE_COL[p] +: ENTRY_W];
        e_c3  = row[ENTRY_W*3 +: ENTRY_W];
        c  = $signed({e_col[ENTRY_W-1], e_col});
        c3 = $signed({e_c3[ENTRY_W-1], e_c3});
        if (PLANE_NEG[p]) begin
            c = -c;
        end
        if (PLANE_USES_COL3[p]) begin
            c = c + c3;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/aabb_frustum_cull_core.sv
// aabb_frustum_cull_core: classifies axis-aligned boxes against six frustum
// planes taken from a configured matrix. Depends on aafc_pkg and aafc_plane.
//
// Use:
//   config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   one 64-bit matrix row: index 0..3 = x, y, z and translation rows, each
//   four Q4.12 entries, column 0 in the low bits. o_cfg_ready is always high.
//   Rows may only change while no box is in flight.
//   input channel (i_in_valid/o_in_ready) carries one box as min and max
//   corners; output channel (o_out_valid/i_out_ready) returns o_visibility:
//   outside, partial or inside.
//   Path: each box passes the input register, the product register and
//   the result register in that order; a stall can hold it in any of them.
//   Throughput: one box per cycle while i_out_ready stays high; each
//   plane has its own multipliers, so the three register stages run
//   fully overlapped.
//   Stalls: when the receiver holds i_out_ready low the stages fill up and
//   o_in_ready drops once all three hold a box; nothing is dropped.
//   Reset: all stages empty, matrix rows cleared to zero (every box then
//   reads as inside).
`timescale 1ns / 1ps

module aabb_frustum_cull_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [aafc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [aafc_pkg::ROW_W-1:0]             i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [COORD_BITS-1:0]           i_min_x,
    input  logic signed [COORD_BITS-1:0]           i_min_y,
    input  logic signed [COORD_BITS-1:0]           i_min_z,
    input  logic signed [COORD_BITS-1:0]           i_max_x,
    input  logic signed [COORD_BITS-1:0]           i_max_y,
    input  logic signed [COORD_BITS-1:0]           i_max_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [aafc_pkg::VIS_W-1:0]             o_visibility
);
    import aafc_pkg::*;

    logic [ROW_W-1:0]             r_row_x;
    logic [ROW_W-1:0]             r_row_y;
    logic [ROW_W-1:0]             r_row_z;
    logic [ROW_W-1:0]             r_row_w;

    logic                         r_v1;
    logic                         r_v2;
    logic                         r_v3;
    logic signed [COORD_BITS-1:0] r_lo [AXIS_N];
    logic signed [COORD_BITS-1:0] r_hi [AXIS_N];
    logic [VIS_W-1:0]             r_vis;
    logic [VIS_W-1:0]             n_vis;

    logic                         w_rdy1;
    logic                         w_rdy2;
    logic                         w_rdy3;
    t_plane                       w_coef  [PLANE_N];
    t_plane_flags                 w_flags [PLANE_N];
    logic [PLANE_N-1:0]           w_far_neg;
    logic [PLANE_N-1:0]           w_near_neg;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= '0;
            r_row_y <= '0;
            r_row_z <= '0;
            r_row_w <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_X: r_row_x <= i_cfg_data;
                CFG_ROW_Y: r_row_y <= i_cfg_data;
                CFG_ROW_Z: r_row_z <= i_cfg_data;
                CFG_ROW_W: r_row_w <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control
    assign w_rdy3     = !r_v3 || i_out_ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_rdy1) begin
            r_lo[0] <= i_min_x;
            r_lo[1] <= i_min_y;
            r_lo[2] <= i_min_z;
            r_hi[0] <= i_max_x;
            r_hi[1] <= i_max_y;
            r_hi[2] <= i_max_z;
        end
    end

    // plane tests
    for (genvar p = 0; p < PLANE_N; p++) begin : g_plane
        assign w_coef[p].nx = plane_coef(r_row_x, p);
        assign w_coef[p].ny = plane_coef(r_row_y, p);
        assign w_coef[p].nz = plane_coef(r_row_z, p);
        assign w_coef[p].d  = plane_coef(r_row_w, p);

        aafc_plane #(
            .COORD_BITS(COORD_BITS)
        ) u_plane (
            .i_clk  (i_clk),
            .i_load (r_v1 && w_rdy2),
            .i_coef (w_coef[p]),
            .i_lo   (r_lo),
            .i_hi   (r_hi),
            .o_flags(w_flags[p])
        );

        assign w_far_neg[p]  = w_flags[p].far_neg;
        assign w_near_neg[p] = w_flags[p].near_neg;
    end

    always_comb begin
        if (|w_far_neg) begin
            n_vis = VIS_OUTSIDE;
        end else if (|w_near_neg) begin
            n_vis = VIS_PARTIAL;
        end else begin
            n_vis = VIS_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_rdy3) begin
            r_vis <= n_vis;
        end
    end

    assign o_out_valid  = r_v3;
    assign o_visibility = r_vis;

endmodule

>>> hw/rtl/aafc_plane.sv
// aafc_plane: one frustum plane test, corner select and product register,
// then the signed sums behind it. Depends on aafc_pkg.
`timescale 1ns / 1ps

module aafc_plane #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  aafc_pkg::t_plane             i_coef,
    input  logic signed [COORD_BITS-1:0] i_lo [aafc_pkg::AXIS_N],
    input  logic signed [COORD_BITS-1:0] i_hi [aafc_pkg::AXIS_N],
    output aafc_pkg::t_plane_flags       o_flags
);
    import aafc_pkg::*;

    localparam int PROD_W = COEF_W + COORD_BITS;
    localparam int SUM_W  = PROD_W + 2;

    t_coef                     w_n [AXIS_N];
    logic signed [PROD_W-1:0]  n_far_prod [AXIS_N];
    logic signed [PROD_W-1:0]  n_near_prod [AXIS_N];
    logic signed [PROD_W-1:0]  r_far_prod [AXIS_N];
    logic signed [PROD_W-1:0]  r_near_prod [AXIS_N];
    t_coef                     r_off;
    logic signed [SUM_W-1:0]   w_far_sum;
    logic signed [SUM_W-1:0]   w_near_sum;

    assign w_n[0] = i_coef.nx;
    assign w_n[1] = i_coef.ny;
    assign w_n[2] = i_coef.nz;

    // a positive normal takes max as p-corner, otherwise min
    always_comb begin
        for (int a = 0; a < AXIS_N; a++) begin
            if (w_n[a] > 0) begin
                n_far_prod[a]  = PROD_W'(w_n[a]) * PROD_W'(i_hi[a]);
                n_near_prod[a] = PROD_W'(w_n[a]) * PROD_W'(i_lo[a]);
            end else begin
                n_far_prod[a]  = PROD_W'(w_n[a]) * PROD_W'(i_lo[a]);
                n_near_prod[a] = PROD_W'(w_n[a]) * PROD_W'(i_hi[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_far_prod  <= n_far_prod;
            r_near_prod <= n_near_prod;
            r_off       <= i_coef.d;
        end
    end

    assign w_far_sum  = SUM_W'(r_far_prod[0]) + SUM_W'(r_far_prod[1])
                      + SUM_W'(r_far_prod[2]) + SUM_W'(r_off);
    assign w_near_sum = SUM_W'(r_near_prod[0]) + SUM_W'(r_near_prod[1])
                      + SUM_W'(r_near_prod[2]) + SUM_W'(r_off);

    assign o_flags.far_neg  = w_far_sum[SUM_W-1];
    assign o_flags.near_neg = w_near_sum[SUM_W-1];

endmodule

>>> hw/rtl/aafc_checker.sv
// aafc_checker: port-level assertions for aabb_frustum_cull_core, bound to
// the top level below. Depends on aafc_pkg.
`timescale 1ns / 1ps

module aafc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [aafc_pkg::VIS_W-1:0]    o_visibility
);
    import aafc_pkg::*;

    // empty output means the whole pipe can take an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with output stage empty");

    a_vis_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_visibility == VIS_OUTSIDE || o_visibility == VIS_PARTIAL
                         || o_visibility == VIS_INSIDE))
        else $error("visibility code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_visibility))
        else $error("result changed while stalled");

    // an accepted item goes through product and result registers to the output
    a_in_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##2 o_out_valid)
        else $error("accepted item never reached the output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind aabb_frustum_cull_core aafc_checker u_aafc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_visibility(o_visibility)
);

>>> bench/aafc_tb_pkg.sv
// aafc_tb_pkg: box item type, random box and matrix entry helpers and the
// visibility scoreboard for the frustum cull bench. Depends on aafc_pkg.
`timescale 1ns / 1ps

package aafc_tb_pkg;

    import aafc_pkg::*;

    localparam int CRD_W = 16;

    localparam logic [ENTRY_W-1:0] Q_ONE     = 16'h1000;
    localparam logic [ENTRY_W-1:0] Q_NEG_ONE = 16'hF000;

    // plane order
    localparam int PL_LEFT   = 0;
    localparam int PL_RIGHT  = 1;
    localparam int PL_BOTTOM = 2;
    localparam int PL_TOP    = 3;
    localparam int PL_NEAR   = 4;
    localparam int PL_FAR    = 5;

    typedef logic [VIS_W-1:0] t_vis;

    typedef struct packed {
        logic signed [CRD_W-1:0] min_x;
        logic signed [CRD_W-1:0] min_y;
        logic signed [CRD_W-1:0] min_z;
        logic signed [CRD_W-1:0] max_x;
        logic signed [CRD_W-1:0] max_y;
        logic signed [CRD_W-1:0] max_z;
    } t_box;

    function automatic t_box mk_box(input int mnx, input int mny, input int mnz,
                                    input int mxx, input int mxy, input int mxz);
        t_box b;
        b.min_x = 16'(mnx);
        b.min_y = 16'(mny);
        b.min_z = 16'(mnz);
        b.max_x = 16'(mxx);
        b.max_y = 16'(mxy);
        b.max_z = 16'(mxz);
        return b;
    endfunction

    function automatic logic [ROW_W-1:0] pack_row(input logic [ENTRY_W-1:0] c0,
                                                  input logic [ENTRY_W-1:0] c1,
                                                  input logic [ENTRY_W-1:0] c2,
                                                  input logic [ENTRY_W-1:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    // entry in -span..+span, Q4.12
    function automatic logic [ENTRY_W-1:0] rand_entry(input int span);
        int v;
        v = int'($urandom_range(2 * span)) - span;
        return v[ENTRY_W-1:0];
    endfunction

    // mostly small boxes near the origin where the planes cut, some inverted,
    // some with fully random fields
    function automatic t_box rand_box();
        t_box b;
        int sel;
        int ctr;
        int half;
        int lo [3];
        int hi [3];
        sel = int'($urandom_range(99));
        if (sel < 15) begin
            b = {$urandom, $urandom, $urandom};
        end else begin
            for (int a = 0; a < 3; a++) begin
                ctr = int'($urandom_range(80)) - 40;
                half = int'($urandom_range(24));
                lo[a] = ctr - half;
                hi[a] = ctr + half;
            end
            if (sel < 25) begin
                b = mk_box(hi[0], hi[1], hi[2], lo[0], lo[1], lo[2]);
            end else begin
                b = mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
            end
        end
        return b;
    endfunction

    class cull_scoreboard;
        logic [ROW_W-1:0] row_x;
        logic [ROW_W-1:0] row_y;
        logic [ROW_W-1:0] row_z;
        logic [ROW_W-1:0] row_w;
        t_vis expected_vis [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned n_outside;
        int unsigned n_partial;
        int unsigned n_inside;

        function new();
            row_x = '0;
            row_y = '0;
            row_z = '0;
            row_w = '0;
            mismatches = 0;
            checked = 0;
            n_outside = 0;
            n_partial = 0;
            n_inside = 0;
        endfunction

        function void set_row(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] v);
            case (idx)
                CFG_ROW_X: begin
                    row_x = v;
                end
                CFG_ROW_Y: begin
                    row_y = v;
                end
                CFG_ROW_Z: begin
                    row_z = v;
                end
                default: begin
                    row_w = v;
                end
            endcase
        endfunction

        // plane coefficient in Q.12, exact
        function longint plane_term(input logic [ROW_W-1:0] row, input int p);
            logic signed [ENTRY_W-1:0] e0;
            logic signed [ENTRY_W-1:0] e1;
            logic signed [ENTRY_W-1:0] e2;
            logic signed [ENTRY_W-1:0] e3;
            longint c0;
            longint c1;
            longint c2;
            longint c3;
            e0 = row[15:0];
            e1 = row[31:16];
            e2 = row[47:32];
            e3 = row[63:48];
            c0 = e0;
            c1 = e1;
            c2 = e2;
            c3 = e3;
            case (p)
                PL_LEFT:   return c3 + c0;
                PL_RIGHT:  return c3 - c0;
                PL_BOTTOM: return c3 + c1;
                PL_TOP:    return c3 - c1;
                PL_NEAR:   return c2;
                default:   return c3 - c2;
            endcase
        endfunction

        function t_vis classify_box(input t_box b);
            longint lo [3];
            longint hi [3];
            logic [ROW_W-1:0] rows [3];
            longint n;
            longint far_dot;
            longint near_dot;
            bit partial;
            lo[0] = b.min_x;
            lo[1] = b.min_y;
            lo[2] = b.min_z;
            hi[0] = b.max_x;
            hi[1] = b.max_y;
            hi[2] = b.max_z;
            rows[0] = row_x;
            rows[1] = row_y;
            rows[2] = row_z;
            partial = 1'b0;
            for (int p = 0; p < PLANE_N; p++) begin
                far_dot = plane_term(row_w, p);
                near_dot = far_dot;
                for (int a = 0; a < 3; a++) begin
                    n = plane_term(rows[a], p);
                    // zero normal takes min as p-corner, the term vanishes anyway
                    if (n > 0) begin
                        far_dot += n * hi[a];
                        near_dot += n * lo[a];
                    end else begin
                        far_dot += n * lo[a];
                        near_dot += n * hi[a];
                    end
                end
                if (far_dot < 0) begin
                    return VIS_OUTSIDE;
                end
                if (near_dot < 0) begin
                    partial = 1'b1;
                end
            end
            return partial ? VIS_PARTIAL : VIS_INSIDE;
        endfunction

        function void note_box(input t_box b);
            t_vis v;
            v = classify_box(b);
            case (v)
                VIS_OUTSIDE: begin
                    n_outside++;
                end
                VIS_PARTIAL: begin
                    n_partial++;
                end
                default: begin
                    n_inside++;
                end
            endcase
            expected_vis.push_back(v);
        endfunction

        function void check_vis(input t_vis got);
            t_vis want;
            if (expected_vis.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("visibility %0d returned with no box pending", got);
                end
            end else begin
                want = expected_vis.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("box %0d: visibility expected %0d, got %0d",
                                 checked, want, got);
                    end
                end
                checked++;
            end
        endfunction

        function int pending();
            return expected_vis.size();
        endfunction

        function void flush_leftover();
            if (expected_vis.size() != 0) begin
                mismatches += expected_vis.size();
                $display("%0d boxes never got a visibility result", expected_vis.size());
                expected_vis.delete();
            end
        endfunction
    endclass

endpackage

>>> bench/aabb_frustum_cull_core_tb.sv
// aabb_frustum_cull_core_tb: drives boxes and matrix rows into the cull core
// and checks every visibility result. Depends on aafc_pkg and aafc_tb_pkg.
`timescale 1ns / 1ps

module aabb_frustum_cull_core_tb;

    import aafc_pkg::*;
    import aafc_tb_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 64;
    localparam int PHASE_ITEMS   = 130;
    localparam int PHASE_COUNT   = 10;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [ROW_W-1:0]            i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic signed [CRD_W-1:0]     i_min_x;
    logic signed [CRD_W-1:0]     i_min_y;
    logic signed [CRD_W-1:0]     i_min_z;
    logic signed [CRD_W-1:0]     i_max_x;
    logic signed [CRD_W-1:0]     i_max_y;
    logic signed [CRD_W-1:0]     i_max_z;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [VIS_W-1:0]            o_visibility;

    cull_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_reqs;
    int quiet_cycles = 0;

    aabb_frustum_cull_core #(
        .COORD_BITS(CRD_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_min_x     (i_min_x),
        .i_min_y     (i_min_y),
        .i_min_z     (i_min_z),
        .i_max_x     (i_max_x),
        .i_max_y     (i_max_y),
        .i_max_z     (i_max_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_visibility(o_visibility)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // called at a falling edge; leaves valid high after the item is taken
    task automatic send_box(input t_box b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_min_x = b.min_x;
        i_min_y = b.min_y;
        i_min_z = b.min_z;
        i_max_x = b.max_x;
        i_max_y = b.max_y;
        i_max_z = b.max_z;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        board.note_box(b);
        @(negedge i_clk);
    endtask

    task automatic write_row(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        board.set_row(idx, v);
        @(negedge i_clk);
    endtask

    task automatic load_matrix(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                               input logic [ROW_W-1:0] rz, input logic [ROW_W-1:0] rw);
        write_row(CFG_ROW_X, rx);
        write_row(CFG_ROW_Y, ry);
        write_row(CFG_ROW_Z, rz);
        write_row(CFG_ROW_W, rw);
        i_cfg_valid = 1'b0;
    endtask

    // drain the pipe before touching the matrix
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (board.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin
        int hold_seen;
        hold_seen = 0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_vis(o_visibility);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [ROW_W-1:0] rx;
        logic [ROW_W-1:0] ry;
        logic [ROW_W-1:0] rz;
        logic [ROW_W-1:0] rw;
        board = new();
        hold_reqs = 0;
        send_idle_pct = 21;
        recv_idle_pct = 70;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROW_X;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_min_x = '0;
        i_min_y = '0;
        i_min_z = '0;
        i_max_x = '0;
        i_max_y = '0;
        i_max_z = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // rows still at reset: every box reads as inside
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        send_box(mk_box(0, 0, 0, 0, 0, 0));

        // plain frustum |x| <= z, |y| <= z, z >= 1; far plane has a zero normal
        wait_idle();
        load_matrix(pack_row(Q_ONE, '0, '0, '0), pack_row('0, Q_ONE, '0, '0),
                    pack_row('0, '0, Q_ONE, Q_ONE), pack_row('0, '0, Q_NEG_ONE, '0));
        send_box(mk_box(0, 0, 10, 2, 2, 12));
        send_box(mk_box(-1, -1, -10, 1, 1, -5));
        send_box(mk_box(-100, -1, 10, -50, 1, 12));
        send_box(mk_box(50, -1, 10, 100, 1, 12));
        send_box(mk_box(-1, -100, 10, 1, -50, 12));
        send_box(mk_box(-1, 50, 10, 1, 100, 12));
        send_box(mk_box(-20, 0, 10, 0, 1, 12));
        send_box(mk_box(0, 0, -5, 1, 1, 5));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        send_box(mk_box(-32768, 32767, -32768, 32767, -32768, 32767));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(5, 5, 12, -5, -5, 8));

        for (int k = 0; k < PHASE_COUNT; k++) begin
            wait_idle();
            if (k < 4) begin
                send_idle_pct = 21;
                recv_idle_pct = 70;
            end else if (k < 7) begin
                send_idle_pct = 70;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (k)
                0, 8: begin
                    rx = pack_row(Q_ONE + rand_entry(256), '0, '0, '0);
                    ry = pack_row('0, Q_ONE + rand_entry(256), '0, '0);
                    rz = pack_row('0, '0, Q_ONE + rand_entry(256), Q_ONE + rand_entry(256));
                    rw = pack_row(rand_entry(4096), rand_entry(4096),
                                  Q_NEG_ONE + rand_entry(512), rand_entry(4096));
                end
                2: begin
                    rx = '0;
                    ry = '0;
                    rz = '0;
                    rw = '0;
                end
                3: begin
                    rx = '1;
                    ry = '1;
                    rz = '1;
                    rw = '1;
                end
                4: begin
                    rx = {4{16'h8000}};
                    ry = {4{16'h8000}};
                    rz = {4{16'h8000}};
                    rw = {4{16'h8000}};
                end
                5: begin
                    rx = {4{16'h7FFF}};
                    ry = {4{16'h7FFF}};
                    rz = {4{16'h7FFF}};
                    rw = {4{16'h7FFF}};
                end
                6: begin
                    rx = pack_row(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
                    ry = pack_row(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
                    rz = pack_row(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
                    rw = {$urandom, $urandom};
                end
                7: begin
                    rx = {$urandom, $urandom};
                    ry = {$urandom, $urandom};
                    rz = {$urandom, $urandom};
                    rw = {$urandom, $urandom};
                end
                default: begin
                    rx = pack_row(rand_entry(8192), rand_entry(8192),
                                  rand_entry(8192), rand_entry(8192));
                    ry = pack_row(rand_entry(8192), rand_entry(8192),
                                  rand_entry(8192), rand_entry(8192));
                    rz = pack_row(rand_entry(8192), rand_entry(8192),
                                  rand_entry(8192), rand_entry(8192));
                    rw = {$urandom, $urandom};
                end
            endcase
            load_matrix(rx, ry, rz, rw);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold so the stages fill and input stalls
                if ((k == 1 || k == 8) && n == 40) begin
                    hold_reqs = hold_reqs + 1;
                end
                send_box(rand_box());
            end
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        board.flush_leftover();
        $display("boxes sent %0d over %0d matrix settings and reset rows: outside %0d, partial %0d, inside %0d",
                 board.n_outside + board.n_partial + board.n_inside, PHASE_COUNT + 1,
                 board.n_outside, board.n_partial, board.n_inside);
        $display("results checked %0d, mismatches %0d", board.checked, board.mismatches);
        if (board.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
